/* hdl/lru_cache_with_locked_entries_macros.svh */
// Assertion macros shared by the checker of the LRU table block.
// No dependencies.
`ifndef LRU_CACHE_WITH_LOCKED_ENTRIES_MACROS_SVH
`define LRU_CACHE_WITH_LOCKED_ENTRIES_MACROS_SVH
// Implication checked on every clock edge outside of reset.
`define LRU_ASSERT_IMP(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) else $error(msg);
// Next-cycle implication checked outside of reset.
`define LRU_ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) else $error(msg);
`endif

/* hdl/lru_pkg.sv */
// Package for the LRU table block: sizes, operation and status codes, payload types.
// No dependencies.
`timescale 1ns / 1ps
package lru_pkg;
   localparam int TableSlots = 64;
   localparam int LockBits   = 8;
   localparam int SlotBits   = $clog2(TableSlots);
   localparam int CountBits  = $clog2(TableSlots + 1);
   localparam int QueueDepth = 2;

   localparam logic [2:0] OP_ADD    = 3'd0;
   localparam logic [2:0] OP_REMOVE = 3'd1;
   localparam logic [2:0] OP_ACCESS = 3'd2;
   localparam logic [2:0] OP_LOCK   = 3'd3;
   localparam logic [2:0] OP_UNLOCK = 3'd4;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_DUPLICATE = 3'd1;
   localparam logic [2:0] ST_NOT_FOUND = 3'd2;
   localparam logic [2:0] ST_LOCKED    = 3'd3;
   localparam logic [2:0] ST_NO_ROOM   = 3'd4;
   localparam logic [2:0] ST_FULL      = 3'd5;

   localparam logic [6:0] MaxActiveReset = 7'd64;

   typedef struct packed {
      logic [2:0]  operation;
      logic [31:0] entry_key;
      logic        arrives_loaded;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic        hit;
      logic        load_request;
      logic        evict_valid;
      logic [31:0] evict_key;
      logic [31:0] hit_total;
      logic [31:0] miss_total;
   } rsp_type;
endpackage

/* hdl/lru_cache_with_locked_entries.sv */
// Top level of the LRU table with locked entries: register port, front queue, back sequencer.
// Depends on lru_pkg, lru_front and lru_back.
//
// Use: transactions enter on req_valid/req_stall carrying operation, entry_key and
// arrives_loaded; one response per transaction leaves on rsp_valid/rsp_stall.
// max_active is written over the csr_ APB port at byte address 0 and reads back.
// Each transaction takes these steps: the back end takes it from the queue, makes a pass
// over the slot memories to find the key and the lowest free slot, makes a second pass
// for the oldest unlocked loaded entry, executes the operation and presents the response.
// The single read port of those memories calls for the two passes; the back end takes a
// new transaction only after the last response has left. A two-entry queue accepts
// transactions while the back end works. A stalled response holds and the back end
// waits; the queue then fills and raises req_stall. Synchronous reset empties the queue,
// clears all slots and counters and sets max_active to 64.
`timescale 1ns / 1ps
module lru_cache_with_locked_entries (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  lru_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output lru_pkg::rsp_type rsp_data,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [1:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   logic [6:0]       max_ff, max_in;
   logic             q_valid, q_take;
   lru_pkg::req_type q_data;

   assign csr_pready = 1'b1;
   assign csr_prdata = {25'd0, max_ff};

   // Configuration register write.
   always_comb begin
      max_in = max_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_paddr == 2'd0)
         max_in = csr_pwdata[6:0];
   end

   always_ff @(posedge clock) begin
      if (reset) max_ff <= lru_pkg::MaxActiveReset;
      else max_ff <= max_in;
   end

   lru_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .q_valid, .q_take, .q_data
   );

   lru_back u_back (
      .clock, .reset, .q_valid, .q_take, .q_data,
      .max_active (max_ff), .rsp_valid, .rsp_stall, .rsp_data
   );
endmodule

/* hdl/lru_front.sv */
// Front end of the LRU table block: accepts transactions and queues them.
// Depends on lru_pkg.
`timescale 1ns / 1ps
module lru_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  lru_pkg::req_type req_data,
   output logic             q_valid,
   input  logic             q_take,
   output lru_pkg::req_type q_data
);
   localparam int PtrBits = $clog2(lru_pkg::QueueDepth);

   lru_pkg::req_type         mem_ff [lru_pkg::QueueDepth];
   logic [PtrBits-1:0]       wr_ff, wr_in, rd_ff, rd_in;
   logic [PtrBits:0]         cnt_ff, cnt_in;
   logic                     push, pop;

   assign req_stall = (cnt_ff == PtrBits'(0) + (PtrBits+1)'(lru_pkg::QueueDepth));
   assign push      = req_valid && !req_stall;
   assign pop       = q_valid && q_take;
   assign q_valid   = (cnt_ff != '0);
   assign q_data    = mem_ff[rd_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (PtrBits+1)'(push) - (PtrBits+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= req_data;
      end
   end
endmodule

/* hdl/lru_back.sv */
// Back end of the LRU table block: sequencer that scans the slots and applies operations.
// Depends on lru_pkg.
`timescale 1ns / 1ps
module lru_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   output logic             q_take,
   input  lru_pkg::req_type q_data,
   input  logic [6:0]       max_active,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output lru_pkg::rsp_type rsp_data
);
   localparam int SB = lru_pkg::SlotBits;
   localparam int CB = lru_pkg::CountBits;
   localparam int LB = lru_pkg::LockBits;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_FIND = 5'b00010,
      S_VICT = 5'b00100,
      S_EXEC = 5'b01000,
      S_OUT  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic [lru_pkg::TableSlots-1:0] valid_ff, valid_in, loaded_ff, loaded_in;
   logic [31:0]    key_mem [lru_pkg::TableSlots];
   logic [31:0]    stamp_mem [lru_pkg::TableSlots];
   // Lock counts need no reset: an add writes zero before a slot's count is ever used.
   logic [LB-1:0]  lock_mem [lru_pkg::TableSlots];

   logic [CB-1:0]  loaded_cnt_ff, loaded_cnt_in;
   logic [31:0]    clock_ff, hits_ff, misses_ff;

   lru_pkg::req_type cur_ff;
   logic [SB-1:0]  idx_ff;
   logic [SB:0]    step_ff;
   logic           found_ff, free_ok_ff, vic_ok_ff;
   logic [SB-1:0]  found_slot_ff, free_ff, vic_ff;
   logic [LB-1:0]  found_lock_ff, rd_lock_ff;
   logic [31:0]    vic_stamp_ff, rd_key_ff, rd_stamp_ff, vic_key_ff;
   logic [SB-1:0]  rd_idx_ff;
   logic           rd_ok_ff;
   lru_pkg::rsp_type out_ff;

   logic [31:0]    wr_key, wr_stamp;
   logic [LB-1:0]  wr_lock;
   logic           wr_key_en, wr_stamp_en, wr_lock_en;
   logic [SB-1:0]  wr_key_idx, wr_stamp_idx, wr_lock_idx;

   logic           need_room, room_ok, do_evict;
   logic [2:0]     st;
   logic           ex_hit, ex_load;
   logic [SB-1:0]  tgt;

   assign q_take    = (state_ff == S_IDLE) && q_valid;
   assign rsp_valid = (state_ff == S_OUT);
   assign rsp_data  = out_ff;

   // Memory reads are registered: address issued in one cycle, data checked in the next.
   always_ff @(posedge clock) begin
      rd_key_ff   <= key_mem[idx_ff];
      rd_stamp_ff <= stamp_mem[idx_ff];
      rd_lock_ff  <= lock_mem[idx_ff];
      rd_idx_ff   <= idx_ff;
      if (wr_key_en) key_mem[wr_key_idx] <= wr_key;
      if (wr_stamp_en) stamp_mem[wr_stamp_idx] <= wr_stamp;
      if (wr_lock_en) lock_mem[wr_lock_idx] <= wr_lock;
   end

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (q_valid) state_in = S_FIND;
         S_FIND: if (step_ff == (SB+1)'(lru_pkg::TableSlots)) state_in = S_VICT;
         S_VICT: if (step_ff == (SB+1)'(lru_pkg::TableSlots)) state_in = S_EXEC;
         S_EXEC: state_in = S_OUT;
         S_OUT:  if (!rsp_stall) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // Execute stage decisions.
   always_comb begin
      need_room = ({1'b0, loaded_cnt_ff} >= {1'b0, max_active}) ;
      room_ok   = !need_room || vic_ok_ff;
      do_evict  = 1'b0;
      st        = lru_pkg::ST_OK;
      ex_hit    = 1'b0;
      ex_load   = 1'b0;
      tgt       = found_slot_ff;
      unique case (cur_ff.operation) inside
         lru_pkg::OP_ADD: begin
            tgt = free_ff;
            if (found_ff) st = lru_pkg::ST_DUPLICATE;
            else if (!free_ok_ff) st = lru_pkg::ST_FULL;
            else if (cur_ff.arrives_loaded) begin
               if (room_ok) begin
                  ex_load  = 1'b1;
                  do_evict = need_room;
               end else st = lru_pkg::ST_NO_ROOM;
            end
         end
         lru_pkg::OP_REMOVE: begin
            if (!found_ff) st = lru_pkg::ST_NOT_FOUND;
            else if (found_lock_ff != '0) st = lru_pkg::ST_LOCKED;
         end
         lru_pkg::OP_ACCESS: begin
            if (!found_ff) st = lru_pkg::ST_NOT_FOUND;
            else if (loaded_ff[found_slot_ff]) ex_hit = 1'b1;
            else if (room_ok) begin
               ex_load  = 1'b1;
               do_evict = need_room;
            end else st = lru_pkg::ST_NO_ROOM;
         end
         lru_pkg::OP_LOCK, lru_pkg::OP_UNLOCK: begin
            if (!found_ff) st = lru_pkg::ST_NOT_FOUND;
         end
         default: ;
      endcase
   end

   // Memory write selection.
   always_comb begin
      wr_key_en    = (state_ff == S_EXEC) && cur_ff.operation == lru_pkg::OP_ADD
                     && !found_ff && free_ok_ff;
      wr_key_idx   = free_ff;
      wr_key       = cur_ff.entry_key;
      wr_stamp_en  = (state_ff == S_EXEC) && (ex_hit || ex_load);
      wr_stamp_idx = tgt;
      wr_stamp     = clock_ff;
      // A new entry starts unlocked; lock and unlock move the count captured by the scan.
      wr_lock_en   = 1'b0;
      wr_lock_idx  = tgt;
      wr_lock      = '0;
      if (wr_key_en) begin
         wr_lock_en = 1'b1;
      end else if (state_ff == S_EXEC && found_ff) begin
         if (cur_ff.operation == lru_pkg::OP_LOCK && found_lock_ff != {LB{1'b1}}) begin
            wr_lock_en = 1'b1;
            wr_lock    = found_lock_ff + 1'b1;
         end else if (cur_ff.operation == lru_pkg::OP_UNLOCK && found_lock_ff != '0) begin
            wr_lock_en = 1'b1;
            wr_lock    = found_lock_ff - 1'b1;
         end
      end
   end

   // Slot flags and loaded count after the execute step.
   always_comb begin
      valid_in      = valid_ff;
      loaded_in     = loaded_ff;
      loaded_cnt_in = loaded_cnt_ff;
      if (state_ff == S_EXEC) begin
         if (do_evict) begin
            loaded_in[vic_ff] = 1'b0;
            if (loaded_cnt_in != '0) loaded_cnt_in = loaded_cnt_in - 1'b1;
         end
         if (ex_load) begin
            loaded_in[tgt] = 1'b1;
            loaded_cnt_in  = loaded_cnt_in + 1'b1;
         end
         if (cur_ff.operation == lru_pkg::OP_REMOVE && st == lru_pkg::ST_OK) begin
            if (loaded_ff[tgt] && loaded_cnt_in != '0) loaded_cnt_in = loaded_cnt_in - 1'b1;
            valid_in[tgt]  = 1'b0;
            loaded_in[tgt] = 1'b0;
         end
         if (cur_ff.operation == lru_pkg::OP_ADD && st != lru_pkg::ST_DUPLICATE
             && st != lru_pkg::ST_FULL) begin
            valid_in[tgt] = 1'b1;
            if (!ex_load) loaded_in[tgt] = 1'b0;
         end
      end
   end

   // Scan and table update.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         valid_ff      <= '0;
         loaded_ff     <= '0;
         loaded_cnt_ff <= '0;
         clock_ff      <= '0;
         hits_ff       <= '0;
         misses_ff     <= '0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         loaded_ff     <= loaded_in;
         loaded_cnt_ff <= loaded_cnt_in;
         unique case (state_ff)
            S_IDLE: begin
               cur_ff     <= q_data;
               idx_ff     <= '0;
               step_ff    <= '0;
               found_ff   <= 1'b0;
               free_ok_ff <= 1'b0;
               vic_ok_ff  <= 1'b0;
               rd_ok_ff   <= 1'b0;
            end
            S_FIND: begin
               // Issue address idx, check data from the previous address.
               if (rd_ok_ff) begin
                  if (valid_ff[rd_idx_ff] && rd_key_ff == cur_ff.entry_key && !found_ff) begin
                     found_ff      <= 1'b1;
                     found_slot_ff <= rd_idx_ff;
                     found_lock_ff <= rd_lock_ff;
                  end
                  if (!valid_ff[rd_idx_ff] && !free_ok_ff) begin
                     free_ok_ff <= 1'b1;
                     free_ff    <= rd_idx_ff;
                  end
               end
               rd_ok_ff <= (step_ff < (SB+1)'(lru_pkg::TableSlots - 1)) || (step_ff ==
                           (SB+1)'(lru_pkg::TableSlots - 1));
               idx_ff   <= idx_ff + 1'b1;
               step_ff  <= step_ff + 1'b1;
               if (step_ff == (SB+1)'(lru_pkg::TableSlots)) begin
                  idx_ff   <= '0;
                  step_ff  <= '0;
                  rd_ok_ff <= 1'b0;
               end
            end
            S_VICT: begin
               if (rd_ok_ff && valid_ff[rd_idx_ff] && loaded_ff[rd_idx_ff]
                   && rd_lock_ff == '0
                   && (!vic_ok_ff || rd_stamp_ff < vic_stamp_ff)) begin
                  vic_ok_ff    <= 1'b1;
                  vic_ff       <= rd_idx_ff;
                  vic_stamp_ff <= rd_stamp_ff;
                  vic_key_ff   <= rd_key_ff;
               end
               rd_ok_ff <= (step_ff < (SB+1)'(lru_pkg::TableSlots));
               idx_ff   <= idx_ff + 1'b1;
               step_ff  <= step_ff + 1'b1;
            end
            S_EXEC: begin
               out_ff.status       <= st;
               out_ff.hit          <= ex_hit;
               out_ff.load_request <= ex_load && cur_ff.operation == lru_pkg::OP_ACCESS;
               out_ff.evict_valid  <= do_evict;
               out_ff.evict_key    <= do_evict ? vic_key_ff : 32'd0;
               out_ff.hit_total    <= hits_ff + 32'(ex_hit);
               out_ff.miss_total   <= misses_ff
                                      + 32'(ex_load && cur_ff.operation == lru_pkg::OP_ACCESS);
               if (ex_hit) hits_ff <= hits_ff + 1'b1;
               if (ex_load && cur_ff.operation == lru_pkg::OP_ACCESS)
                  misses_ff <= misses_ff + 1'b1;
               if (ex_hit || ex_load) clock_ff <= clock_ff + 1'b1;
            end
            S_OUT: ;
            default: ;
         endcase
      end
   end
endmodule

/* hdl/lru_checker.sv */
// Port checker for the LRU table block, bound to the top level.
// Depends on lru_pkg and the macros header.
`timescale 1ns / 1ps
`include "lru_cache_with_locked_entries_macros.svh"
module lru_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input lru_pkg::rsp_type rsp_data
);
   `LRU_ASSERT_IMP(a_status_range, clock, reset, rsp_valid, rsp_data.status <= lru_pkg::ST_FULL, "status out of range")
   `LRU_ASSERT_IMP(a_hit_ok, clock, reset, rsp_valid && rsp_data.hit, rsp_data.status == lru_pkg::ST_OK && !rsp_data.load_request, "hit with bad fields")
   `LRU_ASSERT_IMP(a_evict_key, clock, reset, rsp_valid && !rsp_data.evict_valid, rsp_data.evict_key == 32'd0, "evict key without eviction")
   `LRU_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled response changed")
endmodule

bind lru_cache_with_locked_entries lru_checker u_checker (
   .clock, .reset, .rsp_valid, .rsp_stall, .rsp_data
);

/* tb/lru_cache_with_locked_entries_tb.sv */
// Self-checking testbench for the LRU table with locked entries.
// Depends on lru_pkg and lru_cache_with_locked_entries; predicts every response in-line.
`timescale 1ns / 1ps
module lru_cache_with_locked_entries_tb;
   localparam int SLOTS = lru_pkg::TableSlots;
   localparam int LOCK_MAX = (1 << lru_pkg::LockBits) - 1;
   localparam int WATCHDOG = 200000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   lru_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   lru_pkg::rsp_type rsp_data;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   lru_cache_with_locked_entries u_dut (.*);

   // Clock generation.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Shadow copy of the table.
   logic [6:0]  lim_active;
   logic        tb_valid [SLOTS];
   logic [31:0] tb_key [SLOTS];
   logic        tb_loaded [SLOTS];
   logic [lru_pkg::LockBits-1:0] tb_lock [SLOTS];
   logic [31:0] tb_stamp [SLOTS];
   logic [6:0]  tb_loaded_cnt;
   logic [31:0] tb_clock, tb_hits, tb_misses;

   lru_pkg::rsp_type expected_rsps[$];
   int errors = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int quiet_cycles = 0;
   logic [31:0] key_pool [8];

   // Free one loaded slot if the limit is reached; returns 0 when nothing can go.
   function automatic bit evict_if_full(ref lru_pkg::rsp_type r);
      int victim = -1;
      if (tb_loaded_cnt < lim_active) return 1'b1;
      for (int i = 0; i < SLOTS; i++) begin
         if (!tb_valid[i] || !tb_loaded[i] || tb_lock[i] != 0) continue;
         if (victim < 0 || tb_stamp[i] < tb_stamp[victim]) victim = i;
      end
      if (victim < 0) return 1'b0;
      tb_loaded[victim] = 1'b0;
      if (tb_loaded_cnt > 0) tb_loaded_cnt--;
      r.evict_valid = 1'b1;
      r.evict_key = tb_key[victim];
      return 1'b1;
   endfunction

   function automatic void load_slot(int s);
      tb_loaded[s] = 1'b1;
      tb_stamp[s] = tb_clock;
      tb_clock++;
      tb_loaded_cnt++;
   endfunction

   // Table behavior for one transaction.
   function automatic lru_pkg::rsp_type predict_table(lru_pkg::req_type q);
      lru_pkg::rsp_type r = '0;
      int s = -1;
      int f = -1;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (tb_valid[i] && tb_key[i] == q.entry_key) s = i;
         if (!tb_valid[i]) f = i;
      end
      r.status = lru_pkg::ST_OK;
      case (q.operation)
         lru_pkg::OP_ADD: begin
            if (s >= 0) r.status = lru_pkg::ST_DUPLICATE;
            else if (f < 0) r.status = lru_pkg::ST_FULL;
            else begin
               tb_valid[f] = 1'b1;
               tb_key[f] = q.entry_key;
               tb_loaded[f] = 1'b0;
               tb_lock[f] = '0;
               tb_stamp[f] = '0;
               if (q.arrives_loaded) begin
                  if (evict_if_full(r)) load_slot(f);
                  else r.status = lru_pkg::ST_NO_ROOM;
               end
            end
         end
         lru_pkg::OP_REMOVE: begin
            if (s < 0) r.status = lru_pkg::ST_NOT_FOUND;
            else if (tb_lock[s] != 0) r.status = lru_pkg::ST_LOCKED;
            else begin
               if (tb_loaded[s] && tb_loaded_cnt > 0) tb_loaded_cnt--;
               tb_valid[s] = 1'b0;
               tb_loaded[s] = 1'b0;
            end
         end
         lru_pkg::OP_ACCESS: begin
            if (s < 0) r.status = lru_pkg::ST_NOT_FOUND;
            else if (tb_loaded[s]) begin
               r.hit = 1'b1;
               tb_hits++;
               tb_stamp[s] = tb_clock;
               tb_clock++;
            end else if (evict_if_full(r)) begin
               r.load_request = 1'b1;
               tb_misses++;
               load_slot(s);
            end else r.status = lru_pkg::ST_NO_ROOM;
         end
         lru_pkg::OP_LOCK: begin
            if (s < 0) r.status = lru_pkg::ST_NOT_FOUND;
            else if (tb_lock[s] < LOCK_MAX) tb_lock[s]++;
         end
         lru_pkg::OP_UNLOCK: begin
            if (s < 0) r.status = lru_pkg::ST_NOT_FOUND;
            else if (tb_lock[s] > 0) tb_lock[s]--;
         end
         default: ;
      endcase
      r.hit_total = tb_hits;
      r.miss_total = tb_misses;
      return r;
   endfunction

   // Send one transaction and record its expected response.
   // Valid stays high after acceptance until the next send or a drain changes it.
   task automatic send_op(logic [2:0] op, logic [31:0] key, logic ld);
      lru_pkg::req_type q;
      q.operation = op;
      q.entry_key = key;
      q.arrives_loaded = ld;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= q;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_rsps.push_back(predict_table(q));
   endtask

   task automatic drain_rsps();
      req_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   task automatic write_max_active(logic [6:0] v);
      drain_rsps();
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= '0;
      csr_pwdata <= {25'd0, v};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      lim_active = v;
   endtask

   // Random operation biased toward a small key pool so entries are reused.
   task automatic send_random();
      logic [2:0] op;
      logic [31:0] key;
      int p = $urandom_range(99);
      op = (p < 30) ? lru_pkg::OP_ACCESS : (p < 55) ? lru_pkg::OP_ADD :
           (p < 68) ? lru_pkg::OP_REMOVE : (p < 82) ? lru_pkg::OP_LOCK :
           (p < 97) ? lru_pkg::OP_UNLOCK : 3'($urandom_range(7, 5));
      key = ($urandom_range(99) < 92) ? key_pool[$urandom_range(7)] : $urandom();
      send_op(op, key, 1'($urandom()));
   endtask

   // Extremes, each operation, the duplicate, not-found and locked cases and undefined codes.
   task automatic test_directed();
      send_op(lru_pkg::OP_ACCESS, 32'h0, 1'b0);
      send_op(lru_pkg::OP_ADD, 32'hFFFF_FFFF, 1'b1);
      send_op(lru_pkg::OP_ADD, 32'hFFFF_FFFF, 1'b0);
      send_op(lru_pkg::OP_ACCESS, 32'hFFFF_FFFF, 1'b0);
      send_op(lru_pkg::OP_ADD, 32'h0, 1'b0);
      send_op(lru_pkg::OP_ACCESS, 32'h0, 1'b0);
      send_op(lru_pkg::OP_UNLOCK, 32'h0, 1'b0);
      send_op(lru_pkg::OP_LOCK, 32'h0, 1'b0);
      send_op(lru_pkg::OP_REMOVE, 32'h0, 1'b0);
      send_op(lru_pkg::OP_UNLOCK, 32'h0, 1'b0);
      send_op(lru_pkg::OP_REMOVE, 32'h0, 1'b0);
      send_op(lru_pkg::OP_REMOVE, 32'h5555_AAAA, 1'b0);
      send_op(lru_pkg::OP_LOCK, 32'h5555_AAAA, 1'b0);
      send_op(lru_pkg::OP_UNLOCK, 32'h5555_AAAA, 1'b0);
      send_op(3'd5, 32'h0, 1'b1);
      send_op(3'd7, 32'hFFFF_FFFF, 1'b1);
      // Lock count saturation.
      for (int i = 0; i < 260; i++) send_op(lru_pkg::OP_LOCK, 32'hFFFF_FFFF, 1'b0);
      for (int i = 0; i < 256; i++) send_op(lru_pkg::OP_UNLOCK, 32'hFFFF_FFFF, 1'b0);
   endtask

   // Tiny limit with locks: eviction and no-room paths.
   task automatic test_small_limit();
      write_max_active(7'd1);
      send_op(lru_pkg::OP_ADD, 32'h10, 1'b1);
      send_op(lru_pkg::OP_ADD, 32'h11, 1'b1);
      send_op(lru_pkg::OP_LOCK, 32'h11, 1'b0);
      send_op(lru_pkg::OP_ADD, 32'h12, 1'b1);
      send_op(lru_pkg::OP_ACCESS, 32'h12, 1'b0);
      send_op(lru_pkg::OP_UNLOCK, 32'h11, 1'b0);
      send_op(lru_pkg::OP_ACCESS, 32'h12, 1'b0);
      write_max_active(7'd0);
      send_op(lru_pkg::OP_ACCESS, 32'h11, 1'b0);
      send_op(lru_pkg::OP_ACCESS, 32'h10, 1'b0);
      write_max_active(7'd127);
      for (int i = 0; i < 3; i++) send_op(lru_pkg::OP_REMOVE, 32'h10 + i, 1'b0);
   endtask

   // Fill the table to provoke the table-full status.
   task automatic test_table_full();
      write_max_active(7'd64);
      for (int i = 0; i < SLOTS + 2; i++)
         send_op(lru_pkg::OP_ADD, 32'h1000 + i, 1'($urandom()));
      for (int i = 0; i < SLOTS; i++) send_op(lru_pkg::OP_REMOVE, 32'h1000 + i, 1'b0);
   endtask

   task automatic test_random(int n, logic [6:0] lim);
      write_max_active(lim);
      for (int i = 0; i < 8; i++) key_pool[i] = $urandom();
      key_pool[0] = 32'h0;
      key_pool[1] = 32'hFFFF_FFFF;
      for (int i = 0; i < n; i++) begin
         send_random();
         if (i == n / 2) drain_rsps();
      end
   endtask

   // Response checker with random stall.
   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected response %p", $time, rsp_data);
               errors++;
            end else begin
               lru_pkg::rsp_type e;
               e = expected_rsps.pop_front();
               if (rsp_data !== e) begin
                  $display("%0t: expected %p actual %p", $time, e, rsp_data);
                  errors++;
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Watchdog on cycles with no accepted transaction, response or register access.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset || csr_psel)
         quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > WATCHDOG) begin
         $display("lru_cache_with_locked_entries: mismatch");
         $finish;
      end
   end

   initial begin
      lim_active = lru_pkg::MaxActiveReset;
      for (int i = 0; i < SLOTS; i++) begin
         tb_valid[i] = 0; tb_key[i] = 0; tb_loaded[i] = 0; tb_lock[i] = 0; tb_stamp[i] = 0;
      end
      tb_loaded_cnt = 0; tb_clock = 0; tb_hits = 0; tb_misses = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_small_limit();
      test_table_full();
      send_idle_pct = 17; recv_idle_pct = 79;
      test_random(300, 7'd3);
      send_idle_pct = 79; recv_idle_pct = 17;
      test_random(300, 7'd1);
      send_idle_pct = 0; recv_idle_pct = 0;
      test_random(400, 7'd64);
      test_random(276, 7'd5);
      drain_rsps();
      if (errors == 0) $display("lru_cache_with_locked_entries: match");
      else $display("lru_cache_with_locked_entries: mismatch");
      $finish;
   end
endmodule

/* filelist.f */
+incdir+hdl
hdl/lru_pkg.sv
hdl/lru_front.sv
hdl/lru_back.sv
hdl/lru_cache_with_locked_entries.sv
hdl/lru_checker.sv
tb/lru_cache_with_locked_entries_tb.sv
